FILE: sv/shortest_path_distances_assert.svh
// ---------------------------------------------------------------------------
// shortest path distances assertion macros
// clocked concurrent checks with async reset disable
// ---------------------------------------------------------------------------
`ifndef SHORTEST_PATH_DISTANCES_ASSERT_SVH
`define SHORTEST_PATH_DISTANCES_ASSERT_SVH

// implication checked every clock while out of reset
`define SPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/spd_pkg.sv
// ---------------------------------------------------------------------------
// spd_pkg
// shared types and constants of the shortest path distances block
// ---------------------------------------------------------------------------
package spd_pkg;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam int DIST_W = 24;
  localparam int WGT_W  = 16;
  localparam int NODE_W = 6;

  localparam logic [DIST_W-1:0] DIST_NONE = 24'hFFFFFF;
  localparam logic [DIST_W-1:0] DIST_CAP  = 24'hFFFFFE;

  typedef struct packed {
    logic [NODE_W-1:0] from;
    logic [NODE_W-1:0] to;
    logic [WGT_W-1:0]  weight;
  } edge_t;

endpackage

FILE: sv/shortest_path_distances.sv
// ---------------------------------------------------------------------------
// shortest path distances
// single-source shortest paths over a stored directed edge list
// ---------------------------------------------------------------------------
// input beats carry an edge add, an edge clear or a run from a start node.
// node_count_i is to be written with node_count_we_i only while the block is idle; the block does not enforce this.
// add and clear give no output beat.
// a run first sets every distance entry to unreached and a valid start
// node to zero, then does up to N rounds: a select scan over all N nodes
// in the distance memory and a relax scan over the filled edges, each
// relax step a read-modify-write of the distance memory with forwarding.
// a run then gives N output beats, one node per beat in ascending order,
// tlast on the final node.
// the edge memory and the distance memory each have one registered read
// port; they set the throughput.
// a held output beat stalls the output scan only; nothing is lost.
// reset empties the edge store, clears the dropped flag and sets node
// count to MAX_NODES; no memory clearing pass is needed.
// ---------------------------------------------------------------------------
module shortest_path_distances #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        node_count_we_i,
  input  logic [6:0]  node_count_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // func
  input  logic [39:0] s_axis_tdata,   // edge_from, edge_to, edge_weight, start_node, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tlast,
  output logic [31:0] m_axis_tdata    // node, distance, reachable, edges_dropped
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW = $clog2(MAX_EDGES + 1);
  localparam int DW = spd_pkg::DIST_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INIT   = 3'd1;
  localparam logic [2:0] ST_SEL    = 3'd2;
  localparam logic [2:0] ST_RELAX  = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  spd_pkg::edge_t edge_mem [MAX_EDGES];
  logic [DW-1:0]  dist_mem [MAX_NODES];
  logic           fin_mem  [MAX_NODES];

  logic [2:0]     st_q;
  logic [6:0]     cnt_reg_q;
  logic [6:0]     cnt_q;
  logic [FW-1:0]  fill_q;
  logic           drop_q;
  logic [6:0]     idx_q;
  logic [FW:0]    eidx_q;
  logic           rv_q;
  logic [6:0]     ridx_q;
  logic [6:0]     round_q;
  logic [NW:0]    pick_q;
  logic [DW-1:0]  pick_d_q;
  spd_pkg::edge_t erd_q;
  logic           erv_q;
  logic [DW-1:0]  drd_q;
  logic           frd_q;
  logic           wb_v_q;
  logic [NW-1:0]  wb_a_q;
  logic [DW-1:0]  wb_d_q;
  logic           ov_q;
  logic [NW-1:0]  on_q;
  logic [DW-1:0]  od_q;
  logic           ol_q;
  logic           odp_q;
  logic [5:0]     in_start_q;
  logic           start_ok_q;
  spd_pkg::edge_t erd_raw_q;
  logic           erv_raw_q;

  logic [5:0]  in_from, in_to, in_start;
  logic [15:0] in_w;
  logic        acc;
  logic [6:0]  used;
  logic        out_adv;

  assign in_from  = s_axis_tdata[5:0];
  assign in_to    = s_axis_tdata[11:6];
  assign in_w     = s_axis_tdata[27:12];
  assign in_start = s_axis_tdata[33:28];
  assign s_axis_tready = (st_q == ST_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign used = (cnt_reg_q == 7'd0) ? 7'd1 :
                (cnt_reg_q > 7'(MAX_NODES)) ? 7'(MAX_NODES) : cnt_reg_q;
  assign out_adv = !ov_q || m_axis_tready;

  // relax stage: edge read registered in erd_raw_q then erd_q, distance read in drd_q
  // stage 2 compares and writes; forward on matching write-back
  logic           rel_ok;
  logic [DW:0]    rel_sum;
  logic [DW-1:0]  rel_new, rel_cur;
  logic           rel_wr;
  logic [DW-1:0]  sel_cur;

  assign rel_ok  = erv_q && (erd_q.from == pick_q[NW-1:0]) && (7'(erd_q.from) < cnt_q)
                   && (7'(erd_q.to) < cnt_q);
  assign rel_sum = {1'b0, pick_d_q} + (DW+1)'(erd_q.weight);
  assign rel_new = (rel_sum > (DW+1)'(spd_pkg::DIST_CAP)) ? spd_pkg::DIST_CAP : rel_sum[DW-1:0];
  assign rel_cur = (wb_v_q && wb_a_q == erd_q.to[NW-1:0]) ? wb_d_q : drd_q;
  assign rel_wr  = (st_q == ST_RELAX) && rel_ok && (rel_new < rel_cur);
  assign sel_cur = drd_q;

  always_ff @(posedge clk_i) begin
    if (st_q == ST_INIT) begin
      dist_mem[idx_q[NW-1:0]] <= (idx_q[NW-1:0] == in_start_q[NW-1:0] && start_ok_q) ?
                                 '0 : spd_pkg::DIST_NONE;
      fin_mem[idx_q[NW-1:0]]  <= 1'b0;
    end else if (rel_wr) begin
      dist_mem[erd_q.to[NW-1:0]] <= rel_new;
    end else if (st_q == ST_SEL && idx_q == cnt_q + 7'd1 && pick_q < (NW+1)'(cnt_q)) begin
      fin_mem[pick_q[NW-1:0]] <= 1'b1;
    end
    if (acc && s_axis_tuser == spd_pkg::FUNC_ADD && fill_q < FW'(MAX_EDGES)) begin
      edge_mem[fill_q[EW-1:0]] <= '{from: in_from, to: in_to, weight: in_w};
    end
  end

  // memory reads, registered
  spd_pkg::edge_t edge_mem_rd;
  logic [NW-1:0]  erd_next_to;
  logic [NW-1:0]  drd_a;
  assign edge_mem_rd = erd_raw_q;
  assign erd_next_to = edge_mem_rd.to[NW-1:0];

  // a held output entry is read again at its own address
  always_comb begin
    drd_a = idx_q[NW-1:0];
    if (st_q == ST_RELAX) drd_a = erd_next_to;
    if (st_q == ST_OUT && !out_adv) drd_a = ridx_q[NW-1:0];
  end

  always_ff @(posedge clk_i) begin
    erd_raw_q <= edge_mem[eidx_q[EW-1:0]];
    drd_q     <= dist_mem[drd_a];
    frd_q     <= fin_mem[idx_q[NW-1:0]];
    erd_q     <= erd_raw_q;
    wb_a_q    <= erd_q.to[NW-1:0];
    wb_d_q    <= rel_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_reg_q <= 7'(MAX_NODES); fill_q <= '0; drop_q <= 1'b0;
      cnt_q <= '0; idx_q <= '0; eidx_q <= '0; rv_q <= 1'b0; ridx_q <= '0;
      round_q <= '0; pick_q <= '0; pick_d_q <= '0; erv_raw_q <= 1'b0; erv_q <= 1'b0;
      wb_v_q <= 1'b0; ov_q <= 1'b0; on_q <= '0; od_q <= '0; ol_q <= 1'b0; odp_q <= 1'b0;
      in_start_q <= '0; start_ok_q <= 1'b0;
    end else begin
      if (node_count_we_i) cnt_reg_q <= node_count_i;
      rv_q   <= 1'b0;
      wb_v_q <= rel_wr;
      erv_q  <= erv_raw_q;
      erv_raw_q <= 1'b0;
      if (out_adv) ov_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (acc) begin
            case (s_axis_tuser)
              spd_pkg::FUNC_ADD: begin
                if (fill_q < FW'(MAX_EDGES)) fill_q <= fill_q + 1'b1;
                else drop_q <= 1'b1;
              end
              spd_pkg::FUNC_CLEAR: begin
                fill_q <= '0; drop_q <= 1'b0;
              end
              spd_pkg::FUNC_RUN: begin
                cnt_q <= used; idx_q <= '0; round_q <= '0;
                in_start_q <= in_start; start_ok_q <= 7'(in_start) < used;
                st_q <= ST_INIT;
              end
              default: ;
            endcase
          end
        end
        ST_INIT: begin
          if (idx_q == 7'(MAX_NODES) - 7'd1) begin
            idx_q <= '0; pick_q <= (NW+1)'(cnt_q); pick_d_q <= spd_pkg::DIST_NONE;
            st_q <= start_ok_q ? ST_SEL : ST_OUT;
          end else idx_q <= idx_q + 7'd1;
        end
        ST_SEL: begin
          // idx_q issues reads; ridx_q tracks returned entry
          if (idx_q < cnt_q) begin
            rv_q <= 1'b1; ridx_q <= idx_q;
          end
          if (rv_q && !frd_q && sel_cur < pick_d_q) begin
            pick_q <= (NW+1)'(ridx_q); pick_d_q <= sel_cur;
          end
          if (idx_q == cnt_q + 7'd1) begin
            idx_q <= '0;
            if (pick_q >= (NW+1)'(cnt_q)) st_q <= ST_OUT;
            else begin
              eidx_q <= '0; st_q <= ST_RELAX;
            end
          end else idx_q <= idx_q + 7'd1;
        end
        ST_RELAX: begin
          if (eidx_q < (FW+1)'(fill_q)) begin
            erv_raw_q <= 1'b1; eidx_q <= eidx_q + 1'b1;
          end else if (!erv_raw_q && !erv_q) begin
            round_q <= round_q + 7'd1; idx_q <= '0;
            pick_q <= (NW+1)'(cnt_q); pick_d_q <= spd_pkg::DIST_NONE;
            st_q <= (round_q + 7'd1 >= cnt_q) ? ST_OUT : ST_SEL;
          end
        end
        ST_OUT: begin
          // idx_q issues reads; rv_q/ridx_q hold returned entry
          if (out_adv) begin
            if (rv_q) begin
              ov_q <= 1'b1; on_q <= ridx_q[NW-1:0]; od_q <= drd_q; odp_q <= drop_q;
              ol_q <= (ridx_q + 7'd1 == cnt_q);
              if (ridx_q + 7'd1 == cnt_q) st_q <= ST_IDLE;
            end
            if (idx_q < cnt_q && !(rv_q && ridx_q + 7'd1 == cnt_q)) begin
              rv_q <= 1'b1; ridx_q <= idx_q; idx_q <= idx_q + 7'd1;
            end
          end else rv_q <= rv_q;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tdata  = {odp_q, (od_q != spd_pkg::DIST_NONE), od_q,
                          (spd_pkg::NODE_W)'(on_q)};

  `include "shortest_path_distances_assert.svh"

  `SPD_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, s_axis_tready, !m_axis_tvalid || st_q == ST_IDLE,
    "ready while busy")
  `SPD_ASSERT_NXT(a_hold_out, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "output beat lost")
  `SPD_ASSERT_IMP(a_fill_max, clk_i, rst_ni, 1'b1, fill_q <= FW'(MAX_EDGES), "fill overflow")

endmodule
